### rtl/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;

  localparam int MAX_SEQS    = 4096;
  localparam int MAX_WORKERS = 64;
  localparam int SEQ_AW      = $clog2(MAX_SEQS);
  localparam int CNT_W       = SEQ_AW + 1;
  localparam int SIZE_W      = 32;
  localparam int OFF_W       = 40;
  localparam int TOT_W       = 44;
  localparam int WK_W        = 7;
  localparam int IDX_W       = 6;
  localparam int ROFF_W      = 41;
  localparam int DIV_CW      = $clog2(TOT_W);

  localparam logic REG_WORKER_COUNT = 1'b0;
  localparam logic REG_POLICY       = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_SDIV, S_SDIV_WAIT, S_SRD, S_SEMIT,
    S_BCAP, S_BCAP_WAIT, S_BAVG, S_BAVG_WAIT, S_BRD, S_BCHK, S_BEMIT, S_OUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DIV_N, CMD_DIV_CAP, CMD_DIV_AVG,
    CMD_SAVE_QR, CMD_SAVE_CAP, CMD_SAVE_AVG, CMD_READ, CMD_TAKE,
    CMD_EMIT_S, CMD_EMIT_B, CMD_NEXT, CMD_FINISH
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic walk_more;
    logic stop;
    logic last_k;
    logic out_take;
  } dp_stat_t;

endpackage

### rtl/sps_ram.sv
`timescale 1ns / 1ps
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/sps_div.sv
`timescale 1ns / 1ps
module sps_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [sps_pkg::TOT_W-1:0] dividend,
  input  logic [sps_pkg::WK_W-1:0]  divisor,
  output logic                      busy,
  output logic [sps_pkg::TOT_W-1:0] quot,
  output logic [sps_pkg::WK_W-1:0]  remd
);
  import sps_pkg::*;

  logic [DIV_CW-1:0] cnt;
  logic [WK_W-1:0]   dvs;
  logic [WK_W:0]     shifted;
  logic              fits;

  assign shifted = {remd, quot[TOT_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(TOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      remd <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[TOT_W-2:0], fits};
      remd <= fits ? WK_W'(shifted - {1'b0, dvs}) : shifted[WK_W-1:0];
    end
  end
endmodule

### rtl/sps_datapath.sv
`timescale 1ns / 1ps
module sps_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  sps_pkg::dp_cmd_t                  cmd,
  output sps_pkg::dp_stat_t                 stat,
  input  logic [sps_pkg::WK_W-1:0]          worker_count,
  input  logic                              balanced_policy,
  input  logic [sps_pkg::SIZE_W-1:0]        seq_size,
  input  logic [sps_pkg::OFF_W-1:0]         seq_offset,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sps_pkg::IDX_W-1:0]         worker_index,
  output logic [sps_pkg::CNT_W-1:0]         run_count,
  output logic signed [sps_pkg::ROFF_W-1:0] run_offset,
  output logic [sps_pkg::TOT_W-1:0]         run_size,
  output logic                              last_worker
);
  import sps_pkg::*;

  logic [CNT_W-1:0]  n, pos, q, cap, c, c_s;
  logic [TOT_W-1:0]  total, taken, avg, acc;
  logic [WK_W-1:0]   rem, w, left;
  logic [IDX_W-1:0]  k;
  logic [OFF_W-1:0]  first_off;
  logic [SIZE_W-1:0] s_rd;
  logic [OFF_W-1:0]  o_rd;
  logic              div_go, div_busy;
  logic [TOT_W-1:0]  div_a, quot;
  logic [WK_W-1:0]   remd;
  logic [TOT_W:0]    acc_s;
  logic [TOT_W+4:0]  lhs, rhs;

  assign w = (worker_count == '0) ? WK_W'(1) :
             (worker_count > WK_W'(MAX_WORKERS)) ? WK_W'(MAX_WORKERS) : worker_count;
  assign left = w - {1'b0, k};
  assign c_s  = q + CNT_W'({1'b0, k} < rem);

  assign div_go = (cmd == CMD_DIV_N) || (cmd == CMD_DIV_CAP) || (cmd == CMD_DIV_AVG);
  always_comb begin
    case (cmd)
      CMD_DIV_N:   div_a = TOT_W'(n);
      CMD_DIV_CAP: div_a = TOT_W'(n - pos);
      default:     div_a = total - taken;
    endcase
  end

  sps_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a),
    .divisor(cmd == CMD_DIV_N ? w : left), .busy(div_busy), .quot(quot), .remd(remd)
  );

  sps_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_SEQS)) u_size (
    .clk(clk), .we(cmd == CMD_LOAD && n < CNT_W'(MAX_SEQS)), .waddr(n[SEQ_AW-1:0]),
    .wdata(seq_size), .raddr(pos[SEQ_AW-1:0]), .rdata(s_rd)
  );

  sps_ram #(.WIDTH(OFF_W), .DEPTH(MAX_SEQS)) u_off (
    .clk(clk), .we(cmd == CMD_LOAD && n < CNT_W'(MAX_SEQS)), .waddr(n[SEQ_AW-1:0]),
    .wdata(seq_offset), .raddr(pos[SEQ_AW-1:0]), .rdata(o_rd)
  );

  assign acc_s = {1'b0, acc} + (TOT_W + 1)'(s_rd);
  assign lhs   = {acc_s, 3'b000} + {2'b00, acc_s, 1'b0};
  assign rhs   = {avg, 3'b000} + {2'b00, avg, 1'b0} + {3'b000, avg};

  assign stat.div_busy  = div_busy;
  assign stat.walk_more = (pos < n) && (c != cap);
  assign stat.stop      = (lhs > rhs) && ({acc, 1'b0} > {1'b0, avg});
  assign stat.last_k    = ({1'b0, k} == w - 1'b1);
  assign stat.out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= '0;
      total <= '0;
      pos   <= '0;
      taken <= '0;
      k     <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          if (n < CNT_W'(MAX_SEQS)) begin
            n     <= n + 1'b1;
            total <= total + TOT_W'(seq_size);
          end
        end
        CMD_TAKE: pos <= pos + 1'b1;
        CMD_NEXT: begin
          k     <= k + 1'b1;
          taken <= taken + acc;
          if (!balanced_policy) begin
            pos <= pos + c_s;
          end
        end
        CMD_FINISH: begin
          n     <= '0;
          total <= '0;
          pos   <= '0;
          taken <= '0;
          k     <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SAVE_QR:  begin q <= quot[CNT_W-1:0]; rem <= remd; acc <= '0; end
      CMD_SAVE_CAP: cap <= quot[CNT_W-1:0];
      CMD_SAVE_AVG: begin avg <= quot; acc <= '0; c <= '0; end
      CMD_TAKE: begin
        acc <= acc_s[TOT_W-1:0];
        c   <= c + 1'b1;
        if (c == '0) begin
          first_off <= o_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT_S || cmd == CMD_EMIT_B) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT_S) begin
      worker_index <= k;
      last_worker  <= stat.last_k;
      run_count    <= c_s;
      run_size     <= '0;
      if (k == '0) begin
        run_offset <= '0;
      end else if (c_s != '0) begin
        run_offset <= signed'({1'b0, o_rd});
      end else begin
        run_offset <= '1;
      end
    end else if (cmd == CMD_EMIT_B) begin
      worker_index <= k;
      last_worker  <= stat.last_k;
      run_count    <= c;
      run_size     <= acc;
      run_offset   <= (c != '0) ? signed'({1'b0, first_off}) : '1;
    end
  end
endmodule

### rtl/sps_ctrl.sv
`timescale 1ns / 1ps
module sps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              last_seq,
  input  logic              balanced_policy,
  input  sps_pkg::dp_stat_t stat,
  output sps_pkg::dp_cmd_t  cmd
);
  import sps_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd = CMD_LOAD;
          if (last_seq) begin
            state_next = balanced_policy ? S_BCAP : S_SDIV;
          end
        end
      end
      S_SDIV: begin
        cmd        = CMD_DIV_N;
        state_next = S_SDIV_WAIT;
      end
      S_SDIV_WAIT: begin
        if (!stat.div_busy) begin
          cmd        = CMD_SAVE_QR;
          state_next = S_SRD;
        end
      end
      S_SRD:   state_next = S_SEMIT;
      S_SEMIT: begin
        cmd        = CMD_EMIT_S;
        state_next = S_OUT;
      end
      S_BCAP: begin
        cmd        = CMD_DIV_CAP;
        state_next = S_BCAP_WAIT;
      end
      S_BCAP_WAIT: begin
        if (!stat.div_busy) begin
          cmd        = CMD_SAVE_CAP;
          state_next = S_BAVG;
        end
      end
      S_BAVG: begin
        cmd        = CMD_DIV_AVG;
        state_next = S_BAVG_WAIT;
      end
      S_BAVG_WAIT: begin
        if (!stat.div_busy) begin
          cmd        = CMD_SAVE_AVG;
          state_next = S_BRD;
        end
      end
      S_BRD:   state_next = stat.walk_more ? S_BCHK : S_BEMIT;
      S_BCHK: begin
        if (stat.stop) begin
          state_next = S_BEMIT;
        end else begin
          cmd        = CMD_TAKE;
          state_next = S_BRD;
        end
      end
      S_BEMIT: begin
        cmd        = CMD_EMIT_B;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_take) begin
          if (stat.last_k) begin
            cmd        = CMD_FINISH;
            state_next = S_IDLE;
          end else begin
            cmd        = CMD_NEXT;
            state_next = balanced_policy ? S_BCAP : S_SRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/sequence_partition_scheduler.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_stall   | seq_size, seq_offset, last_seq
// out     | out_valid / out_stall | worker_index, run_count, run_offset, run_size, last_worker
// cfg     | APB write/read        | worker_count (0x0), balanced_policy (0x4)
// Records load one per cycle. A last record starts partitioning, during which input stalls.
// Static: one 44-step divide shared by all workers, then each worker is read and emitted.
// Balanced: per worker two 44-step divides, then a read and a check for each record taken,
// then the run is closed and emitted.
// Each result waits in the output register until taken. Reset is synchronous; the
// record stores are not cleared.
module sequence_partition_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sps_pkg::SIZE_W-1:0]        seq_size,
  input  logic [sps_pkg::OFF_W-1:0]         seq_offset,
  input  logic                              last_seq,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sps_pkg::IDX_W-1:0]         worker_index,
  output logic [sps_pkg::CNT_W-1:0]         run_count,
  output logic signed [sps_pkg::ROFF_W-1:0] run_offset,
  output logic [sps_pkg::TOT_W-1:0]         run_size,
  output logic                              last_worker,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import sps_pkg::*;

  logic [WK_W-1:0] worker_count;
  logic            balanced_policy;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_count    <= WK_W'(1);
      balanced_policy <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WORKER_COUNT) begin
        worker_count <= pwdata[WK_W-1:0];
      end else begin
        balanced_policy <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_POLICY) ? {31'd0, balanced_policy}
                                           : {{(32 - WK_W){1'b0}}, worker_count};

  sps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .last_seq(last_seq),
    .balanced_policy(balanced_policy), .stat(stat), .cmd(cmd)
  );

  sps_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .worker_count(worker_count),
    .balanced_policy(balanced_policy), .seq_size(seq_size), .seq_offset(seq_offset),
    .out_valid(out_valid), .out_stall(out_stall), .worker_index(worker_index),
    .run_count(run_count), .run_offset(run_offset), .run_size(run_size),
    .last_worker(last_worker)
  );

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while a result is pending");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_count == '0 && worker_index != '0 |-> run_offset == -1)
    else $error("empty run without -1 offset");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_worker |=> !out_valid)
    else $error("result after final worker");

  a_static_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && !balanced_policy |-> run_size == '0)
    else $error("static run with nonzero size");
endmodule
